>>> design/fsws_pkg.sv
// Package for the Fourier series wave synthesizer: sizes, fixed-point constants,
// register and state codes, and elaboration-time builders for the sine and reciprocal tables.
// No dependencies.
package fsws_pkg;

    // Sizing of the block.
    localparam int MAX_POINTS       = 1024;
    localparam int MAX_TERMS        = 128;
    localparam int SINE_TABLE_DEPTH = 1024;

    // Port field widths.
    localparam int IDX_W       = 10;
    localparam int TIME_W      = 21;
    localparam int VALUE_W     = 19;
    localparam int TERMS_W     = 8;
    localparam int POINTS_W    = 11;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 2;

    // Internal widths.
    localparam int N_W         = $clog2(MAX_POINTS + 1);
    localparam int K_W         = $clog2(2 * MAX_TERMS + 1);
    localparam int RECIP_DEPTH = 2 * MAX_TERMS;
    localparam int RIDX_W      = $clog2(RECIP_DEPTH);
    localparam int PHASE_W     = 16;
    localparam int QOFF_W      = 14;
    localparam int SINE_W      = 17;
    localparam int SIDX_W      = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PI_W        = 34;
    localparam int DVD_W       = IDX_W + PI_W + 3;
    localparam int CNT_W       = $clog2(DVD_W);
    localparam int MUL_A_W     = PI_W;
    localparam int MUL_B_W     = 32;
    localparam int PROD_W      = 64;
    localparam int X_W         = 32;
    localparam int ACC_W       = 36;
    localparam int PHASE_SHIFT = 18;

    // Fixed-point constants.
    localparam logic [63:0]          PI_Q32           = 64'd13493037705;
    localparam logic [63:0]          PI_HALF_Q30      = 64'd1686629713;
    localparam logic [MUL_B_W-1:0]   FOUR_OVER_PI_Q30 = 32'd1367130551;
    localparam logic signed [DVD_W:0] FOUR_PI_Q32     = (DVD_W + 1)'(64'd53972150820);
    localparam logic signed [DVD_W:0] TIME_ROUND      = (DVD_W + 1)'(32768);
    localparam logic signed [ACC_W-1:0] ACC_ROUND     = ACC_W'(8192);
    localparam logic signed [ACC_W-1:0] ACC_VAL_MAX   = ACC_W'(262143);
    localparam logic signed [ACC_W-1:0] ACC_VAL_MIN   = ACC_W'(-262144);

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WAVE_MODE   = 2'd0,
        REG_TERM_COUNT  = 2'd1,
        REG_POINT_COUNT = 2'd2
    } cfg_reg_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_T_MUL,
        ST_T_LOAD,
        ST_T_DIV,
        ST_T_FIN,
        ST_P_DIV,
        ST_P_INIT,
        ST_H_ROM,
        ST_H_MUL,
        ST_H_RECIP,
        ST_H_QK,
        ST_H_ACC,
        ST_DONE
    } fsm_state_t;

    typedef logic [SINE_W-1:0]  sine_rom_t  [SINE_TABLE_DEPTH + 1];
    typedef logic [MUL_B_W-1:0] recip_rom_t [RECIP_DEPTH];

    // Quarter-wave sine in Q16, from an integer Taylor series in Q30.
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t          rom;
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] sum;
        for (int j = 0; j <= SINE_TABLE_DEPTH; j++)
        begin
            x    = (64'(j) * PI_HALF_Q30 + 64'(SINE_TABLE_DEPTH / 2)) / 64'(SINE_TABLE_DEPTH);
            term = x;
            sum  = $signed(x);
            for (int n = 1; n <= 8; n++)
            begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / 64'((2 * n) * (2 * n + 1));
                if ((n % 2) == 1)
                begin
                    sum = sum - $signed(term);
                end
                else
                begin
                    sum = sum + $signed(term);
                end
            end
            if (sum < 0)
            begin
                sum = '0;
            end
            rom[j] = SINE_W'((64'(sum) + 64'd8192) >> 14);
        end
        return rom;
    endfunction

    // Reciprocals floor(2^32 / k) for k = 1 .. RECIP_DEPTH; k = 1 uses 2^32 - 1.
    // The quotient estimate is then at most one low and needs one correction.
    function automatic recip_rom_t build_recip_rom();
        recip_rom_t rom;
        rom[0] = '1;
        for (int k = 2; k <= RECIP_DEPTH; k++)
        begin
            rom[k - 1] = MUL_B_W'((64'd1 << 32) / 64'(k));
        end
        return rom;
    endfunction

endpackage

>>> design/fsws_sine_rom.sv
// Quarter-wave sine table with a registered read port.
// Depends on fsws_pkg for the table size and the table builder.
module fsws_sine_rom (
    input  logic                        clk,
    input  logic [fsws_pkg::SIDX_W-1:0] addr,
    output logic [fsws_pkg::SINE_W-1:0] rd_data
);
    import fsws_pkg::*;

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    logic [SINE_W-1:0] data_reg;

    // Synchronous read.
    always_ff @(posedge clk)
    begin
        data_reg <= SINE_ROM[addr];
    end

    assign rd_data = data_reg;

endmodule

>>> design/fourier_series_wave_synth.sv
// Top level of the Fourier series wave synthesizer.
// Depends on fsws_pkg and fsws_sine_rom.

// Each input transaction carries a point index; the block returns the sample time
// t = -4pi + index*8pi/point_count and the truncated square or sawtooth Fourier sum at t,
// both signed Q.16. One item is in work at a time and in_ready is high only while the
// sequencer is idle. H is the number of harmonics summed: term_count in square mode,
// 2*term_count in sawtooth mode (term_count clamped to 1..128). Two 47-step passes of a
// bit-serial divider by point_count give the time and the phase step, and each harmonic
// then takes five steps through one shared 34x32 multiplier (table scaling, reciprocal
// division by the harmonic number, remainder check). A finished result waits in the
// output register while the next transaction is accepted. Configuration writes take
// effect at once and are meant for idle periods only.
module fourier_series_wave_synth (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [fsws_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [fsws_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [fsws_pkg::IDX_W-1:0]            point_index,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [fsws_pkg::TIME_W-1:0]    sample_time,
    output logic signed [fsws_pkg::VALUE_W-1:0]   sample_value
);
    import fsws_pkg::*;

    localparam recip_rom_t RECIP_ROM = build_recip_rom();

    // Configuration registers.
    logic                wave_mode_reg;
    logic [TERMS_W-1:0]  term_count_reg;
    logic [POINTS_W-1:0] point_count_reg;

    // Control registers.
    fsm_state_t          state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;

    // Datapath registers.
    logic [IDX_W-1:0]          i_reg, i_next;
    logic [N_W-1:0]            n_reg, n_next;
    logic [K_W-1:0]            kmax_reg, kmax_next;
    logic                      mode_reg, mode_next;
    logic [DVD_W-1:0]          dq_reg, dq_next;
    logic [N_W-1:0]            rem_reg, rem_next;
    logic [PROD_W-1:0]         prod_reg, prod_next;
    logic signed [TIME_W-1:0]  time_reg, time_next;
    logic [PHASE_W-1:0]        phase_reg, phase_next;
    logic [N_W-1:0]            pr_reg, pr_next;
    logic [PHASE_W-1:0]        qs_reg, qs_next;
    logic [N_W-1:0]            rs_reg, rs_next;
    logic [K_W-1:0]            k_reg, k_next;
    logic [MUL_B_W-1:0]        recip_reg, recip_next;
    logic [X_W-1:0]            x_reg, x_next;
    logic [X_W-1:0]            q0_reg, q0_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [TIME_W-1:0]  time_out_reg, time_out_next;
    logic signed [VALUE_W-1:0] value_out_reg, value_out_next;

    // Combinational helpers.
    logic [N_W-1:0]               n_clamp;
    logic [IDX_W-1:0]             i_clamp;
    logic [TERMS_W-1:0]           terms_clamp;
    logic [MUL_A_W-1:0]           mul_a;
    logic [MUL_B_W-1:0]           mul_b;
    logic [MUL_A_W+MUL_B_W-1:0]   mul_full;
    logic [N_W:0]                 div_shift;
    logic                         div_ge;
    logic [N_W:0]                 div_sub;
    logic signed [DVD_W:0]        t_sum;
    logic [N_W:0]                 r_init;
    logic                         ge_init;
    logic [N_W:0]                 r_dbl;
    logic                         ge_dbl;
    logic [N_W:0]                 r_adv;
    logic                         ge_adv;
    logic [K_W:0]                 k_sum;
    logic                         last_k;
    logic [X_W-1:0]               x_comb;
    logic [X_W-1:0]               q_rem;
    logic [X_W-1:0]               q_term;
    logic                         term_neg;
    logic signed [ACC_W-1:0]      v_sum;
    logic signed [ACC_W-1:0]      v_shift;
    logic                         slot_free;
    logic [QOFF_W+SIDX_W-1:0]     idx_wide;
    logic [SIDX_W-1:0]            idx_c;
    logic [SIDX_W-1:0]            rom_addr;
    logic [SINE_W-1:0]            rom_data;

    // Sine table.
    fsws_sine_rom u_sine_rom (
        .clk     (clk),
        .addr    (rom_addr),
        .rd_data (rom_data)
    );

    // Table address from the current harmonic phase, with quadrant mirroring.
    always_comb
    begin
        idx_wide = ((QOFF_W + SIDX_W)'(phase_reg[QOFF_W-1:0]) *
                    (QOFF_W + SIDX_W)'(SINE_TABLE_DEPTH) +
                    (QOFF_W + SIDX_W)'(1 << (QOFF_W - 1))) >> QOFF_W;
        if (idx_wide > (QOFF_W + SIDX_W)'(SINE_TABLE_DEPTH))
        begin
            idx_c = SIDX_W'(SINE_TABLE_DEPTH);
        end
        else
        begin
            idx_c = idx_wide[SIDX_W-1:0];
        end
        if (phase_reg[QOFF_W])
        begin
            rom_addr = SIDX_W'(SINE_TABLE_DEPTH) - idx_c;
        end
        else
        begin
            rom_addr = idx_c;
        end
    end

    // Clamping of the registers and the index at acceptance.
    always_comb
    begin
        if (point_count_reg == '0)
        begin
            n_clamp = N_W'(1);
        end
        else if (point_count_reg > POINTS_W'(MAX_POINTS))
        begin
            n_clamp = N_W'(MAX_POINTS);
        end
        else
        begin
            n_clamp = N_W'(point_count_reg);
        end
        if (N_W'(point_index) >= n_clamp)
        begin
            i_clamp = IDX_W'(n_clamp - N_W'(1));
        end
        else
        begin
            i_clamp = point_index;
        end
        if (term_count_reg == '0)
        begin
            terms_clamp = TERMS_W'(1);
        end
        else if (term_count_reg > TERMS_W'(MAX_TERMS))
        begin
            terms_clamp = TERMS_W'(MAX_TERMS);
        end
        else
        begin
            terms_clamp = term_count_reg;
        end
    end

    // Shared arithmetic: divider step, phase bookkeeping, term correction, rounding.
    always_comb
    begin
        div_shift = {rem_reg, dq_reg[DVD_W-1]};
        div_ge    = div_shift >= (N_W + 1)'(n_reg);
        div_sub   = div_shift - (N_W + 1)'(n_reg);

        t_sum = $signed({1'b0, dq_reg}) - FOUR_PI_Q32 + TIME_ROUND;

        r_init  = (N_W + 1)'(rem_reg) + (N_W + 1)'(n_reg >> 1);
        ge_init = r_init >= (N_W + 1)'(n_reg);
        r_dbl   = {rem_reg, 1'b0};
        ge_dbl  = r_dbl >= (N_W + 1)'(n_reg);
        r_adv   = (N_W + 1)'(pr_reg) + (N_W + 1)'(rs_reg);
        ge_adv  = r_adv >= (N_W + 1)'(n_reg);

        k_sum  = (K_W + 1)'(k_reg) + (mode_reg ? (K_W + 1)'(1) : (K_W + 1)'(2));
        last_k = k_sum > (K_W + 1)'(kmax_reg);

        if (mode_reg)
        begin
            x_comb = {rom_data, (X_W - SINE_W)'(0)};
        end
        else
        begin
            x_comb = prod_reg[X_W+15:16];
        end

        // Reciprocal estimate is exact or one low; the remainder decides.
        q_rem    = x_reg - prod_reg[X_W-1:0];
        q_term   = q0_reg + X_W'(q_rem >= X_W'(k_reg));
        term_neg = phase_reg[PHASE_W-1] ^ (mode_reg & ~k_reg[0]);

        v_sum   = acc_reg + ACC_ROUND;
        v_shift = v_sum >>> 14;

        slot_free = !out_valid_reg || out_ready;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_T_MUL;
                end
            end
            ST_T_MUL:   state_next = ST_T_LOAD;
            ST_T_LOAD:  state_next = ST_T_DIV;
            ST_T_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_T_FIN;
                end
            end
            ST_T_FIN:   state_next = ST_P_DIV;
            ST_P_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_P_INIT;
                end
            end
            ST_P_INIT:  state_next = ST_H_ROM;
            ST_H_ROM:   state_next = ST_H_MUL;
            ST_H_MUL:   state_next = ST_H_RECIP;
            ST_H_RECIP: state_next = ST_H_QK;
            ST_H_QK:    state_next = ST_H_ACC;
            ST_H_ACC:
            begin
                if (last_k)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_H_ROM;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Datapath and handshake outputs per state.
    always_comb
    begin
        i_next         = i_reg;
        n_next         = n_reg;
        kmax_next      = kmax_reg;
        mode_next      = mode_reg;
        dq_next        = dq_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        time_next      = time_reg;
        phase_next     = phase_reg;
        pr_next        = pr_reg;
        qs_next        = qs_reg;
        rs_next        = rs_reg;
        k_next         = k_reg;
        recip_next     = recip_reg;
        x_next         = x_reg;
        q0_next        = q0_reg;
        acc_next       = acc_reg;
        time_out_next  = time_out_reg;
        value_out_next = value_out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        mul_a          = '0;
        mul_b          = '0;
        in_ready       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    i_next    = i_clamp;
                    n_next    = n_clamp;
                    kmax_next = K_W'({terms_clamp, 1'b0});
                    mode_next = wave_mode_reg;
                end
            end
            ST_T_MUL:
            begin
                mul_a = PI_Q32[MUL_A_W-1:0];
                mul_b = MUL_B_W'(i_reg);
            end
            ST_T_LOAD:
            begin
                dq_next  = {prod_reg[DVD_W-4:0], 3'b000};
                rem_next = '0;
                cnt_next = CNT_W'(DVD_W - 1);
            end
            ST_T_DIV, ST_P_DIV:
            begin
                rem_next = div_ge ? div_sub[N_W-1:0] : div_shift[N_W-1:0];
                dq_next  = {dq_reg[DVD_W-2:0], div_ge};
                cnt_next = cnt_reg - CNT_W'(1);
            end
            ST_T_FIN:
            begin
                time_next = t_sum[16 +: TIME_W];
                dq_next   = DVD_W'({i_reg, PHASE_SHIFT'(0)});
                rem_next  = '0;
                cnt_next  = CNT_W'(DVD_W - 1);
            end
            ST_P_INIT:
            begin
                // First harmonic phase: rounded quotient of index*2^18 by the point count.
                phase_next = dq_reg[PHASE_W-1:0] + PHASE_W'(ge_init);
                pr_next    = ge_init ? N_W'(r_init - (N_W + 1)'(n_reg)) : N_W'(r_init);
                // Phase step per harmonic, doubled in square mode.
                if (mode_reg)
                begin
                    qs_next = dq_reg[PHASE_W-1:0];
                    rs_next = rem_reg;
                end
                else
                begin
                    qs_next = {dq_reg[PHASE_W-2:0], 1'b0} + PHASE_W'(ge_dbl);
                    rs_next = ge_dbl ? N_W'(r_dbl - (N_W + 1)'(n_reg)) : N_W'(r_dbl);
                end
                k_next   = K_W'(1);
                acc_next = '0;
            end
            ST_H_MUL:
            begin
                mul_a      = MUL_A_W'(rom_data);
                mul_b      = FOUR_OVER_PI_Q30;
                recip_next = RECIP_ROM[RIDX_W'(k_reg - K_W'(1))];
            end
            ST_H_RECIP:
            begin
                x_next = x_comb;
                mul_a  = MUL_A_W'(x_comb);
                mul_b  = recip_reg;
            end
            ST_H_QK:
            begin
                q0_next = prod_reg[PROD_W-1:X_W];
                mul_a   = MUL_A_W'(prod_reg[PROD_W-1:X_W]);
                mul_b   = MUL_B_W'(k_reg);
            end
            ST_H_ACC:
            begin
                if (term_neg)
                begin
                    acc_next = acc_reg - $signed(ACC_W'(q_term));
                end
                else
                begin
                    acc_next = acc_reg + $signed(ACC_W'(q_term));
                end
                k_next     = k_sum[K_W-1:0];
                pr_next    = ge_adv ? N_W'(r_adv - (N_W + 1)'(n_reg)) : N_W'(r_adv);
                phase_next = phase_reg + qs_reg + PHASE_W'(ge_adv);
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    time_out_next  = time_reg;
                    if (v_shift > ACC_VAL_MAX)
                    begin
                        value_out_next = VALUE_W'(ACC_VAL_MAX);
                    end
                    else if (v_shift < ACC_VAL_MIN)
                    begin
                        value_out_next = VALUE_W'(ACC_VAL_MIN);
                    end
                    else
                    begin
                        value_out_next = v_shift[VALUE_W-1:0];
                    end
                end
            end
            default:
            begin
            end
        endcase

        mul_full  = mul_a * mul_b;
        prod_next = mul_full[PROD_W-1:0];
    end

    // Configuration writes; an index past the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_mode_reg   <= 1'b0;
            term_count_reg  <= TERMS_W'(5);
            point_count_reg <= POINTS_W'(200);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_WAVE_MODE:   wave_mode_reg   <= cfg_data[0];
                REG_TERM_COUNT:  term_count_reg  <= cfg_data[TERMS_W-1:0];
                REG_POINT_COUNT: point_count_reg <= cfg_data[POINTS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        i_reg         <= i_next;
        n_reg         <= n_next;
        kmax_reg      <= kmax_next;
        mode_reg      <= mode_next;
        dq_reg        <= dq_next;
        rem_reg       <= rem_next;
        prod_reg      <= prod_next;
        time_reg      <= time_next;
        phase_reg     <= phase_next;
        pr_reg        <= pr_next;
        qs_reg        <= qs_next;
        rs_reg        <= rs_next;
        k_reg         <= k_next;
        recip_reg     <= recip_next;
        x_reg         <= x_next;
        q0_reg        <= q0_next;
        acc_reg       <= acc_next;
        time_out_reg  <= time_out_next;
        value_out_reg <= value_out_next;
    end

    assign out_valid    = out_valid_reg;
    assign sample_time  = time_out_reg;
    assign sample_value = value_out_reg;

endmodule
